>>> sv/cnlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared types and constants for the card number Luhn classifier.
// ----------------------------------------------------------------------------
package cnlc_pkg;

    localparam int CARD_BITS  = 63;
    localparam int MAX_DIGITS = 19;
    localparam int DIGIT_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int SUM_W      = 8;
    localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
    localparam int STEP_BITS  = 4;

    typedef logic [1:0]         kind_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SUM_W-1:0]   sum_t;

    localparam kind_t KIND_INVALID    = 2'd0;
    localparam kind_t KIND_AMEX       = 2'd1;
    localparam kind_t KIND_MASTERCARD = 2'd2;
    localparam kind_t KIND_VISA       = 2'd3;

    localparam count_t LEN_AMEX  = 5'd15;
    localparam count_t LEN_LONG  = 5'd16;
    localparam count_t LEN_SHORT = 5'd13;

    localparam digit_t DIGIT_TEN = 4'd10;

    // Weight of one digit: doubled in even positions, folded above nine.
    function automatic digit_t luhn_weight(input digit_t d, input logic even_pos);
        logic [DIGIT_W:0] dbl;
        dbl = {d, 1'b0};
        if (!even_pos) begin
            return d;
        end else if (dbl > 5'd9) begin
            return DIGIT_W'(dbl - 5'd9);
        end else begin
            return DIGIT_W'(dbl);
        end
    endfunction

endpackage

>>> sv/card_number_luhn_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// Luhn mod-10 check and card kind classification of one binary card number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one card number word. Only the low
//   NUMBER_BITS bits are used. Output channel m_valid/m_ready carries one
//   result word: card kind, Luhn pass flag, digit count and raw Luhn sum.
//   One word is processed at a time; s_ready is high only while idle.
//   After accept the word passes through conversion, the digit scan and the
//   classify step, which registers the result; a new word is taken once the
//   block is back in idle. Conversion uses a binary-to-decimal shifter (four
//   bits per cycle) followed by the digit scan (one decimal digit per cycle
//   through a single weight and add unit).
//   The result sits in an output register; the next word may be accepted and
//   converted while it waits. If the receiver still stalls when the next
//   result is ready, the block holds in its classify step until m_ready.
//   Synchronous active-low reset returns the block to idle with no result
//   pending.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier
    import cnlc_pkg::*;
#(
    parameter int NUMBER_BITS = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CARD_BITS-1:0] s_card_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_card_kind,
    output logic                 m_luhn_ok,
    output logic [COUNT_W-1:0]   m_digit_count,
    output logic [SUM_W-1:0]     m_luhn_sum
);

    localparam int CONV_STEPS = (NUMBER_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = CONV_STEPS * STEP_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_CLASS = 2'd3;

    localparam count_t LAST_CONV = COUNT_W'(CONV_STEPS - 1);
    localparam count_t LAST_SCAN = COUNT_W'(MAX_DIGITS - 1);

    logic [1:0]          state_reg, state_next;
    logic [PAD_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    count_t              pos_reg, pos_next;
    count_t              count_reg, count_next;
    sum_t                sum_reg, sum_next;
    digit_t              mod_reg, mod_next;
    digit_t              lead_reg, lead_next;
    digit_t              second_reg, second_next;
    digit_t              prev_reg, prev_next;

    logic                m_valid_reg, m_valid_next;
    kind_t               kind_reg, kind_next;
    logic                ok_reg, ok_next;
    count_t              dcnt_reg, dcnt_next;
    sum_t                osum_reg, osum_next;

    logic [BCD_W-1:0]    dabble;
    digit_t              cur_digit;
    digit_t              weight;
    count_t              pos_inc;
    logic [DIGIT_W:0]    mod_sum;
    logic                cls_ok;
    kind_t               cls_kind;
    logic                out_free;

    // Shift four binary bits into the decimal register, add-3 before each.
    always_comb begin
        logic [BCD_W-1:0] v;
        v = bcd_reg;
        for (int k = 0; k < STEP_BITS; k++) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (v[i*DIGIT_W +: DIGIT_W] > 4'd4) begin
                    v[i*DIGIT_W +: DIGIT_W] = v[i*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            v = {v[BCD_W-2:0], bin_reg[PAD_BITS-1-k]};
        end
        dabble = v;
    end

    assign cur_digit = bcd_reg[DIGIT_W-1:0];
    assign pos_inc   = pos_reg + 1'b1;
    assign weight    = luhn_weight(cur_digit, ~pos_inc[0]);
    assign mod_sum   = {1'b0, mod_reg} + {1'b0, weight};

    always_comb begin
        cls_ok   = (count_reg != '0) && (mod_reg == '0);
        cls_kind = KIND_INVALID;
        if (cls_ok) begin
            priority if (count_reg == LEN_AMEX && lead_reg == 4'd3 &&
                         (second_reg == 4'd4 || second_reg == 4'd7)) begin
                cls_kind = KIND_AMEX;
            end else if (count_reg == LEN_LONG && lead_reg == 4'd5 &&
                         second_reg >= 4'd1 && second_reg <= 4'd5) begin
                cls_kind = KIND_MASTERCARD;
            end else if ((count_reg == LEN_LONG || count_reg == LEN_SHORT) &&
                         lead_reg == 4'd4) begin
                cls_kind = KIND_VISA;
            end else begin
                cls_kind = KIND_INVALID;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        mod_next     = mod_reg;
        lead_next    = lead_reg;
        second_next  = second_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        ok_next      = ok_reg;
        dcnt_next    = dcnt_reg;
        osum_next    = osum_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bin_next    = PAD_BITS'(s_card_number[NUMBER_BITS-1:0]);
                    bcd_next    = '0;
                    pos_next    = '0;
                    count_next  = '0;
                    sum_next    = '0;
                    mod_next    = '0;
                    lead_next   = '0;
                    second_next = '0;
                    prev_next   = '0;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = dabble;
                bin_next = bin_reg << STEP_BITS;
                pos_next = pos_inc;
                if (pos_reg == LAST_CONV) begin
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                bcd_next = bcd_reg >> DIGIT_W;
                sum_next = sum_reg + SUM_W'(weight);
                mod_next = (mod_sum >= {1'b0, DIGIT_TEN}) ?
                           DIGIT_W'(mod_sum - {1'b0, DIGIT_TEN}) : DIGIT_W'(mod_sum);
                if (cur_digit != '0) begin
                    count_next  = pos_inc;
                    lead_next   = cur_digit;
                    second_next = prev_reg;
                end
                prev_next = cur_digit;
                pos_next  = pos_inc;
                if (pos_reg == LAST_SCAN) begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = cls_kind;
                    ok_next      = cls_ok;
                    dcnt_next    = count_reg;
                    osum_next    = sum_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        count_reg  <= count_next;
        sum_reg    <= sum_next;
        mod_reg    <= mod_next;
        lead_reg   <= lead_next;
        second_reg <= second_next;
        prev_reg   <= prev_next;
        kind_reg   <= kind_next;
        ok_reg     <= ok_next;
        dcnt_reg   <= dcnt_next;
        osum_reg   <= osum_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_card_kind   = kind_reg;
    assign m_luhn_ok     = ok_reg;
    assign m_digit_count = dcnt_reg;
    assign m_luhn_sum    = osum_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CONV))
        else $error("accepted word did not start conversion");

    a_kind_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_card_kind != KIND_INVALID) |-> m_luhn_ok)
        else $error("card kind reported without Luhn pass");

    a_ok_needs_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_luhn_ok) |-> (m_digit_count != '0))
        else $error("Luhn pass reported for zero digits");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_count <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count out of range");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pos_reg == LAST_SCAN) |=> (state_reg == ST_CLASS))
        else $error("digit scan did not end after last digit");

endmodule
